### rtl/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// shared constants, types and helpers of the ray and sphere intersection unit
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int FIX_W       = 32;
   localparam int RADIUS_W    = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int ROOT_W      = 80;
   localparam int QUO_W       = 32;
   localparam int T_DEN_W     = 64;
   localparam int N_DEN_W     = 31;

   typedef logic signed [FIX_W-1:0] fix_type;

   localparam fix_type FIX_MAX = 32'h7fff_ffff;
   localparam fix_type FIX_MIN = 32'h8000_0000;
   localparam fix_type CENTER_RESET = 32'h0000_0000;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      fix_type [2:0] origin;
      fix_type [2:0] dir;
      fix_type       t_low;
      fix_type       t_high;
   } ray_type;

   typedef struct packed {
      ray_type            ray;
      logic signed [66:0] h;
      logic [63:0]        a;
   } sqrt_tag_type;

   typedef struct packed {
      ray_type    ray;
      logic       ok;
      logic [1:0] sat;
   } tdiv_tag_type;

   typedef struct packed {
      logic          hit;
      fix_type       t;
      fix_type [2:0] point;
      logic [1:0]    sat;
   } ndiv_tag_type;

   // sat: bit 1 below range, bit 0 above range; quotient is offset by 2^31
   function automatic fix_type sat_quo(input logic [1:0] sat, input logic [QUO_W-1:0] quo);
      fix_type res;
      if (sat[1]) begin
         res = FIX_MIN;
      end else if (sat[0]) begin
         res = FIX_MAX;
      end else begin
         res = {~quo[QUO_W-1], quo[QUO_W-2:0]};
      end
      return res;
   endfunction

endpackage

### rtl/rsi_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt_pipe
// pipelined integer square root, one root bit per stage, tag rides along
// ----------------------------------------------------------------------------
module rsi_sqrt_pipe #(
   parameter int ROOT_W = 80,
   parameter int TAG_W  = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [TAG_W-1:0]      out_tag
);

   logic                  vld_ff  [ROOT_W+1];
   logic [ROOT_W+1:0]     rem_ff  [ROOT_W+1];
   logic [2*ROOT_W-1:0]   rad_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]     root_ff [ROOT_W+1];
   logic [TAG_W-1:0]      tag_ff  [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= '0;
      rad_ff[0]  <= in_rad;
      root_ff[0] <= '0;
      tag_ff[0]  <= in_tag;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W+1:0] test;
      logic              take;

      always_comb begin
         trial = {rem_ff[k][ROOT_W-1:0], rad_ff[k][2*ROOT_W-1 -: 2]};
         test  = {root_ff[k], 2'b01};
         take  = (trial >= test);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1]  <= take ? (trial - test) : trial;
         rad_ff[k+1]  <= rad_ff[k] << 2;
         root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], take};
         tag_ff[k+1]  <= tag_ff[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];

endmodule

### rtl/rsi_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div_pipe
// pipelined restoring divider, one quotient bit per stage; the upper part of
// the dividend must already be below the divisor
// ----------------------------------------------------------------------------
module rsi_div_pipe #(
   parameter int DEN_W = 64,
   parameter int QUO_W = 32,
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [DEN_W+QUO_W-1:0]  in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic [TAG_W-1:0]        in_tag,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        out_quo,
   output logic [TAG_W-1:0]        out_tag
);

   logic               vld_ff [QUO_W+1];
   logic [DEN_W-1:0]   rem_ff [QUO_W+1];
   logic [QUO_W-1:0]   low_ff [QUO_W+1];
   logic [QUO_W-1:0]   quo_ff [QUO_W+1];
   logic [DEN_W-1:0]   den_ff [QUO_W+1];
   logic [TAG_W-1:0]   tag_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0] <= in_num[DEN_W+QUO_W-1:QUO_W];
      low_ff[0] <= in_num[QUO_W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      tag_ff[0] <= in_tag;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      always_comb begin
         trial = {rem_ff[k], low_ff[k][QUO_W-1]};
         diff  = trial - {1'b0, den_ff[k]};
         take  = (trial >= {1'b0, den_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_ff[k+1] <= low_ff[k] << 1;
         quo_ff[k+1] <= {quo_ff[k][QUO_W-2:0], take};
         den_ff[k+1] <= den_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];

endmodule

### rtl/ray_sphere_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// tests one ray against the configured sphere and returns t, point and normal
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  req       start / busy         origin, dir, t_low, t_high
//  rsp       rsp_strobe (1 cycle) is_hit, hit_t, point, normal
//  csr       csr_we               csr_index, csr_wdata
//
//  one ray word accepted per cycle while busy is low, fully pipelined
//  a result passes the front end, the square root pipeline, the near and far
//  t dividers, the hit stages, the normal dividers and the output register
//  busy is high only through reset and the cycle after it
//  synchronous reset clears valid bits and loads the sphere registers
//  results are never held off, so the pipeline never stalls
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rsi_pkg::fix_type                   req_origin_x,
   input  rsi_pkg::fix_type                   req_origin_y,
   input  rsi_pkg::fix_type                   req_origin_z,
   input  rsi_pkg::fix_type                   req_dir_x,
   input  rsi_pkg::fix_type                   req_dir_y,
   input  rsi_pkg::fix_type                   req_dir_z,
   input  rsi_pkg::fix_type                   req_t_low,
   input  rsi_pkg::fix_type                   req_t_high,
   input  logic                               csr_we,
   input  logic [rsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rsi_pkg::FIX_W-1:0]          csr_wdata,
   output logic                               rsp_strobe,
   output logic                               rsp_is_hit,
   output rsi_pkg::fix_type                   rsp_hit_t,
   output rsi_pkg::fix_type                   rsp_point_x,
   output rsi_pkg::fix_type                   rsp_point_y,
   output rsi_pkg::fix_type                   rsp_point_z,
   output rsi_pkg::fix_type                   rsp_normal_x,
   output rsi_pkg::fix_type                   rsp_normal_y,
   output rsi_pkg::fix_type                   rsp_normal_z
);

   function automatic rsi_pkg::fix_type sat_fix(input logic signed [48:0] v);
      rsi_pkg::fix_type res;
      if (v[48:31] == '0 || v[48:31] == '1) begin
         res = v[31:0];
      end else if (v[48]) begin
         res = rsi_pkg::FIX_MIN;
      end else begin
         res = rsi_pkg::FIX_MAX;
      end
      return res;
   endfunction

   // sphere registers
   rsi_pkg::fix_type [2:0]             center_ff;
   logic [rsi_pkg::RADIUS_W-1:0]       radius_ff;
   logic                               busy_ff;
   logic                               accept;

   // front end
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   rsi_pkg::ray_type ray1_ff, ray2_ff, ray3_ff, ray4_ff, ray5_ff, ray6_ff, ray7_ff, ray8_ff;
   logic signed [32:0]  lvec2_ff [3];
   logic signed [64:0]  phl3_ff  [3];
   logic signed [63:0]  pdd3_ff  [3];
   logic signed [65:0]  pll3_ff  [3];
   logic [61:0]         r2_3_ff;
   logic signed [66:0]  h4_ff, h5_ff, h6_ff, h7_ff, h8_ff;
   logic [63:0]         a4_ff, a5_ff, a6_ff, a7_ff, a8_ff;
   logic signed [67:0]  c4_ff;
   logic [64:0]         hm5_ff;
   logic [65:0]         cm5_ff;
   logic                cneg5_ff, cneg6_ff, cneg7_ff;
   logic [63:0]         hh6_ff;
   logic [64:0]         hl6_ff;
   logic [65:0]         ll6_ff;
   logic [64:0]         ahch6_ff, ahcl6_ff, alch6_ff, alcl6_ff;
   logic [129:0]        h2_7_ff, ac7_ff;
   logic signed [131:0] d8_ff;

   // square root
   rsi_pkg::sqrt_tag_type             sq_tag_in, sq_tag;
   logic                              sq_valid_in, sq_valid, sq_ok;
   logic [2*rsi_pkg::ROOT_W-1:0]      sq_rad_in;
   logic [rsi_pkg::ROOT_W-1:0]        sq_root;

   // root candidates and t division
   logic                  v9_ff, v10_ff, v11_ff;
   rsi_pkg::ray_type      ray9_ff, ray10_ff;
   logic                  ok9_ff, ok10_ff;
   logic [63:0]           a9_ff, a10_ff, a11_ff;
   logic signed [84:0]    hs_in, root_in, candn_in, candf_in;
   logic signed [84:0]    candn9_ff, candf9_ff;
   logic signed [96:0]    nn10_ff, nf10_ff;
   logic [1:0]            satn_in, satf_in;
   rsi_pkg::tdiv_tag_type tn_tag11_ff, qn_tag;
   logic [1:0]            satf11_ff, qf_sat;
   logic [95:0]           divn11_ff, divf11_ff;
   logic                  qn_valid, qf_valid;
   logic [rsi_pkg::QUO_W-1:0] qn, qf;

   // hit, point and normal division
   logic                  v12_ff, v13_ff, v14_ff, v15_ff, v16_ff;
   logic                  hit12_ff, hit13_ff, hit14_ff, hit15_ff;
   rsi_pkg::fix_type      t12_ff, t13_ff, t14_ff, t15_ff;
   rsi_pkg::ray_type      ray12_ff, ray13_ff;
   rsi_pkg::fix_type      tn_in, tf_in;
   logic                  near_in, far_in;
   logic signed [63:0]    prod13_ff [3];
   rsi_pkg::fix_type [2:0] pt14_in, pt14_ff, pt15_ff;
   logic signed [63:0]    num15_in [3];
   logic signed [63:0]    num15_ff [3];
   logic [1:0]            nsat16_in [3];
   rsi_pkg::ndiv_tag_type ntag16_ff, nx_tag;
   logic [1:0]            saty16_ff, satz16_ff, ny_sat, nz_sat;
   logic [62:0]           nd16_ff [3];
   logic                  nx_valid, ny_valid, nz_valid;
   logic [rsi_pkg::QUO_W-1:0] nx_q, ny_q, nz_q;

   // output word
   logic                  rsp_strobe_ff, rsp_is_hit_ff;
   rsi_pkg::fix_type      rsp_t_ff;
   rsi_pkg::fix_type [2:0] rsp_point_ff, rsp_normal_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         center_ff <= {rsi_pkg::CENTER_RESET, rsi_pkg::CENTER_RESET, rsi_pkg::CENTER_RESET};
         radius_ff <= rsi_pkg::RADIUS_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (rsi_pkg::csr_index_type'(csr_index))
               rsi_pkg::CSR_CENTER_X: center_ff[0] <= csr_wdata;
               rsi_pkg::CSR_CENTER_Y: center_ff[1] <= csr_wdata;
               rsi_pkg::CSR_CENTER_Z: center_ff[2] <= csr_wdata;
               rsi_pkg::CSR_RADIUS:   radius_ff    <= csr_wdata[rsi_pkg::RADIUS_W-1:0];
            endcase
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0; v2_ff  <= 1'b0; v3_ff  <= 1'b0; v4_ff  <= 1'b0;
         v5_ff  <= 1'b0; v6_ff  <= 1'b0; v7_ff  <= 1'b0; v8_ff  <= 1'b0;
         v9_ff  <= 1'b0; v10_ff <= 1'b0; v11_ff <= 1'b0; v12_ff <= 1'b0;
         v13_ff <= 1'b0; v14_ff <= 1'b0; v15_ff <= 1'b0; v16_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff  <= accept;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= sq_valid;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= qn_valid && qf_valid;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
         v16_ff <= v15_ff;
         rsp_strobe_ff <= nx_valid && ny_valid && nz_valid;
      end
   end

   // stages 1 to 8: quadratic coefficients and discriminant
   always_ff @(posedge clock) begin
      ray1_ff.origin <= {req_origin_z, req_origin_y, req_origin_x};
      ray1_ff.dir    <= {req_dir_z, req_dir_y, req_dir_x};
      ray1_ff.t_low  <= req_t_low;
      ray1_ff.t_high <= req_t_high;

      ray2_ff <= ray1_ff;
      for (int i = 0; i < 3; i++) begin
         lvec2_ff[i] <= 33'(ray1_ff.origin[i]) - 33'(center_ff[i]);
      end

      ray3_ff <= ray2_ff;
      for (int i = 0; i < 3; i++) begin
         phl3_ff[i] <= 65'(lvec2_ff[i]) * 65'(ray2_ff.dir[i]);
         pdd3_ff[i] <= 64'(ray2_ff.dir[i]) * 64'(ray2_ff.dir[i]);
         pll3_ff[i] <= 66'(lvec2_ff[i]) * 66'(lvec2_ff[i]);
      end
      r2_3_ff <= {31'b0, radius_ff} * {31'b0, radius_ff};

      ray4_ff <= ray3_ff;
      h4_ff   <= 67'(phl3_ff[0]) + 67'(phl3_ff[1]) + 67'(phl3_ff[2]);
      a4_ff   <= 64'($unsigned(pdd3_ff[0])) + 64'($unsigned(pdd3_ff[1]))
                 + 64'($unsigned(pdd3_ff[2]));
      c4_ff   <= 68'(pll3_ff[0]) + 68'(pll3_ff[1]) + 68'(pll3_ff[2])
                 - $signed({6'b0, r2_3_ff});

      ray5_ff  <= ray4_ff;
      h5_ff    <= h4_ff;
      a5_ff    <= a4_ff;
      hm5_ff   <= h4_ff[66] ? 65'(-h4_ff) : 65'(h4_ff);
      cm5_ff   <= c4_ff[67] ? 66'(-c4_ff) : 66'(c4_ff);
      cneg5_ff <= c4_ff[67];

      ray6_ff  <= ray5_ff;
      h6_ff    <= h5_ff;
      a6_ff    <= a5_ff;
      cneg6_ff <= cneg5_ff;
      hh6_ff   <= 64'(hm5_ff[64:33]) * 64'(hm5_ff[64:33]);
      hl6_ff   <= 65'(hm5_ff[64:33]) * 65'(hm5_ff[32:0]);
      ll6_ff   <= 66'(hm5_ff[32:0]) * 66'(hm5_ff[32:0]);
      ahch6_ff <= 65'(a5_ff[63:32]) * 65'(cm5_ff[65:33]);
      ahcl6_ff <= 65'(a5_ff[63:32]) * 65'(cm5_ff[32:0]);
      alch6_ff <= 65'(a5_ff[31:0]) * 65'(cm5_ff[65:33]);
      alcl6_ff <= 65'(a5_ff[31:0]) * 65'(cm5_ff[32:0]);

      ray7_ff  <= ray6_ff;
      h7_ff    <= h6_ff;
      a7_ff    <= a6_ff;
      cneg7_ff <= cneg6_ff;
      h2_7_ff  <= (130'(hh6_ff) << 66) + (130'(hl6_ff) << 34) + 130'(ll6_ff);
      ac7_ff   <= (130'(ahch6_ff) << 65) + (130'(ahcl6_ff) << 32)
                  + (130'(alch6_ff) << 33) + 130'(alcl6_ff);

      ray8_ff <= ray7_ff;
      h8_ff   <= h7_ff;
      a8_ff   <= a7_ff;
      d8_ff   <= cneg7_ff ? $signed({2'b0, h2_7_ff} + {2'b0, ac7_ff})
                          : $signed({2'b0, h2_7_ff} - {2'b0, ac7_ff});
   end

   // a positive discriminant is below 2^126, so its low bits carry it whole
   always_comb begin
      sq_valid_in   = v8_ff;
      sq_tag_in.ray = ray8_ff;
      sq_tag_in.h   = h8_ff;
      sq_tag_in.a   = a8_ff;
      sq_rad_in     = {2'b0, d8_ff[125:0], 32'b0};
   end

   logic ok8;
   assign ok8 = !d8_ff[131] && (d8_ff != '0) && (a8_ff != '0);

   rsi_sqrt_pipe #(
      .ROOT_W (rsi_pkg::ROOT_W),
      .TAG_W  ($bits(rsi_pkg::sqrt_tag_type) + 1)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid_in),
      .in_rad    (sq_rad_in),
      .in_tag    ({sq_tag_in, ok8}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   ({sq_tag, sq_ok})
   );

   // stages 9 to 11: root candidates, offset by 2^31 * A, range check
   always_comb begin
      hs_in    = 85'(sq_tag.h) <<< 16;
      root_in  = $signed({5'b0, sq_root});
      candn_in = -hs_in - root_in;
      candf_in = root_in - hs_in;
      satn_in  = {nn10_ff[96], !nn10_ff[96] && (nn10_ff[95:0] >= {a10_ff, 32'b0})};
      satf_in  = {nf10_ff[96], !nf10_ff[96] && (nf10_ff[95:0] >= {a10_ff, 32'b0})};
   end

   always_ff @(posedge clock) begin
      ray9_ff   <= sq_tag.ray;
      ok9_ff    <= sq_ok;
      a9_ff     <= sq_tag.a;
      candn9_ff <= candn_in;
      candf9_ff <= candf_in;

      ray10_ff <= ray9_ff;
      ok10_ff  <= ok9_ff;
      a10_ff   <= a9_ff;
      nn10_ff  <= 97'(candn9_ff) + $signed({2'b0, a9_ff, 31'b0});
      nf10_ff  <= 97'(candf9_ff) + $signed({2'b0, a9_ff, 31'b0});

      tn_tag11_ff.ray <= ray10_ff;
      tn_tag11_ff.ok  <= ok10_ff;
      tn_tag11_ff.sat <= satn_in;
      satf11_ff       <= satf_in;
      a11_ff          <= a10_ff;
      divn11_ff       <= (satn_in == 2'b00) ? nn10_ff[95:0] : '0;
      divf11_ff       <= (satf_in == 2'b00) ? nf10_ff[95:0] : '0;
   end

   rsi_div_pipe #(
      .DEN_W (rsi_pkg::T_DEN_W),
      .QUO_W (rsi_pkg::QUO_W),
      .TAG_W ($bits(rsi_pkg::tdiv_tag_type))
   ) u_div_near (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v11_ff),
      .in_num    (divn11_ff),
      .in_den    (a11_ff),
      .in_tag    (tn_tag11_ff),
      .out_valid (qn_valid),
      .out_quo   (qn),
      .out_tag   (qn_tag)
   );

   rsi_div_pipe #(
      .DEN_W (rsi_pkg::T_DEN_W),
      .QUO_W (rsi_pkg::QUO_W),
      .TAG_W (2)
   ) u_div_far (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v11_ff),
      .in_num    (divf11_ff),
      .in_den    (a11_ff),
      .in_tag    (satf11_ff),
      .out_valid (qf_valid),
      .out_quo   (qf),
      .out_tag   (qf_sat)
   );

   // stages 12 to 16: root choice, hit point, normal numerators
   always_comb begin
      tn_in   = rsi_pkg::sat_quo(qn_tag.sat, qn);
      tf_in   = rsi_pkg::sat_quo(qf_sat, qf);
      near_in = (qn_tag.ray.t_low < tn_in) && (tn_in < qn_tag.ray.t_high);
      far_in  = (qn_tag.ray.t_low < tf_in) && (tf_in < qn_tag.ray.t_high);
      for (int i = 0; i < 3; i++) begin
         pt14_in[i]  = sat_fix(49'(ray13_ff.origin[i]) + 49'(prod13_ff[i] >>> 16));
         num15_in[i] = (64'(33'(pt14_ff[i]) - 33'(center_ff[i])) <<< 16)
                       + 64'($signed({1'b0, radius_ff, 31'b0}));
         nsat16_in[i] = {num15_ff[i][63],
                         !num15_ff[i][63] && (num15_ff[i][62:0] >= {radius_ff, 32'b0})};
      end
   end

   always_ff @(posedge clock) begin
      hit12_ff <= qn_tag.ok && (near_in || far_in);
      t12_ff   <= near_in ? tn_in : tf_in;
      ray12_ff <= qn_tag.ray;

      hit13_ff <= hit12_ff;
      t13_ff   <= t12_ff;
      ray13_ff <= ray12_ff;
      for (int i = 0; i < 3; i++) begin
         prod13_ff[i] <= 64'(t12_ff) * 64'(ray12_ff.dir[i]);
      end

      hit14_ff <= hit13_ff;
      t14_ff   <= t13_ff;
      pt14_ff  <= pt14_in;

      hit15_ff <= hit14_ff;
      t15_ff   <= t14_ff;
      pt15_ff  <= pt14_ff;
      for (int i = 0; i < 3; i++) begin
         num15_ff[i] <= num15_in[i];
      end

      ntag16_ff.hit   <= hit15_ff;
      ntag16_ff.t     <= t15_ff;
      ntag16_ff.point <= pt15_ff;
      ntag16_ff.sat   <= nsat16_in[0];
      saty16_ff       <= nsat16_in[1];
      satz16_ff       <= nsat16_in[2];
      for (int i = 0; i < 3; i++) begin
         nd16_ff[i] <= (nsat16_in[i] == 2'b00) ? num15_ff[i][62:0] : '0;
      end
   end

   rsi_div_pipe #(
      .DEN_W (rsi_pkg::N_DEN_W),
      .QUO_W (rsi_pkg::QUO_W),
      .TAG_W ($bits(rsi_pkg::ndiv_tag_type))
   ) u_div_nx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v16_ff),
      .in_num    (nd16_ff[0]),
      .in_den    (radius_ff),
      .in_tag    (ntag16_ff),
      .out_valid (nx_valid),
      .out_quo   (nx_q),
      .out_tag   (nx_tag)
   );

   rsi_div_pipe #(
      .DEN_W (rsi_pkg::N_DEN_W),
      .QUO_W (rsi_pkg::QUO_W),
      .TAG_W (2)
   ) u_div_ny (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v16_ff),
      .in_num    (nd16_ff[1]),
      .in_den    (radius_ff),
      .in_tag    (saty16_ff),
      .out_valid (ny_valid),
      .out_quo   (ny_q),
      .out_tag   (ny_sat)
   );

   rsi_div_pipe #(
      .DEN_W (rsi_pkg::N_DEN_W),
      .QUO_W (rsi_pkg::QUO_W),
      .TAG_W (2)
   ) u_div_nz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v16_ff),
      .in_num    (nd16_ff[2]),
      .in_den    (radius_ff),
      .in_tag    (satz16_ff),
      .out_valid (nz_valid),
      .out_quo   (nz_q),
      .out_tag   (nz_sat)
   );

   // result word, all zero on a miss
   always_ff @(posedge clock) begin
      rsp_is_hit_ff <= nx_tag.hit;
      if (nx_tag.hit) begin
         rsp_t_ff         <= nx_tag.t;
         rsp_point_ff     <= nx_tag.point;
         rsp_normal_ff[0] <= rsi_pkg::sat_quo(nx_tag.sat, nx_q);
         rsp_normal_ff[1] <= rsi_pkg::sat_quo(ny_sat, ny_q);
         rsp_normal_ff[2] <= rsi_pkg::sat_quo(nz_sat, nz_q);
      end else begin
         rsp_t_ff      <= '0;
         rsp_point_ff  <= '0;
         rsp_normal_ff <= '0;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_is_hit   = rsp_is_hit_ff;
   assign rsp_hit_t    = rsp_t_ff;
   assign rsp_point_x  = rsp_point_ff[0];
   assign rsp_point_y  = rsp_point_ff[1];
   assign rsp_point_z  = rsp_point_ff[2];
   assign rsp_normal_x = rsp_normal_ff[0];
   assign rsp_normal_y = rsp_normal_ff[1];
   assign rsp_normal_z = rsp_normal_ff[2];

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_hit |->
         rsp_hit_t == '0 && rsp_point_x == '0 && rsp_normal_x == '0)
      else $error("miss word carries nonzero fields");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      v13_ff && hit13_ff |-> ray13_ff.t_low < t13_ff && t13_ff < ray13_ff.t_high)
      else $error("chosen root outside the open interval");

   a_t_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      qn_valid == qf_valid)
      else $error("near and far dividers out of step");

   a_n_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      nx_valid == ny_valid && ny_valid == nz_valid)
      else $error("normal dividers out of step");

endmodule

### verif/tb_ray_sphere_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_unit
// self-checking bench for the ray and sphere intersection unit: a queue-fed
// driver sends ray words and sphere register writes, a monitor predicts every
// result word with exact wide integer math and compares it field by field
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect_unit;
   import rsi_pkg::*;

   localparam int DRAIN_CYCLES = 180;
   localparam int WATCHDOG     = 6000;
   localparam longint ONE      = 65536;

   typedef logic signed [191:0] wide_t;
   typedef enum {JOB_RAY, JOB_CSR, JOB_DRAIN} job_kind_t;

   typedef struct {
      job_kind_t     kind;
      csr_index_type idx;
      logic [31:0]   wdata;
      ray_type       ray;
      int            gap;
   } job_t;

   typedef struct packed {
      logic          hit;
      fix_type       t;
      fix_type [2:0] point;
      fix_type [2:0] normal;
   } hit_word_t;

   logic clock, reset, start, busy, csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [FIX_W-1:0] csr_wdata;
   ray_type drv_ray;
   logic rsp_strobe, rsp_is_hit;
   fix_type rsp_hit_t, rsp_point_x, rsp_point_y, rsp_point_z;
   fix_type rsp_normal_x, rsp_normal_y, rsp_normal_z;

   job_t      pend_q[$];
   hit_word_t hit_q[$];
   fix_type   sph_center[3];
   longint    sph_radius;
   logic      accepted_q;
   int        errors, idle_cycles, gap_cnt, drain_cnt;
   bit        draining;

   ray_sphere_intersect_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(drv_ray.origin[0]), .req_origin_y(drv_ray.origin[1]),
      .req_origin_z(drv_ray.origin[2]), .req_dir_x(drv_ray.dir[0]),
      .req_dir_y(drv_ray.dir[1]), .req_dir_z(drv_ray.dir[2]),
      .req_t_low(drv_ray.t_low), .req_t_high(drv_ray.t_high),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_is_hit(rsp_is_hit), .rsp_hit_t(rsp_hit_t),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_point_z(rsp_point_z), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic fix_type sat32(longint v);
      if (v > longint'(FIX_MAX)) return FIX_MAX;
      if (v < longint'(FIX_MIN)) return FIX_MIN;
      return fix_type'(v);
   endfunction

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // exact quadratic solve against the mirrored sphere registers
   function automatic hit_word_t trace_sphere(ray_type r);
      hit_word_t res;
      wide_t h, a, c, d, x, nh, cand, q;
      logic [191:0] root, tryv;
      longint l, tt, pp;
      res = '0;
      h = 0;
      a = 0;
      c = 0;
      for (int i = 0; i < 3; i++) begin
         l = longint'(r.origin[i]) - longint'(sph_center[i]);
         h += wide_t'(l) * wide_t'(r.dir[i]);
         a += wide_t'(r.dir[i]) * wide_t'(r.dir[i]);
         c += wide_t'(l) * wide_t'(l);
      end
      c -= wide_t'(sph_radius) * wide_t'(sph_radius);
      d = h * h - a * c;
      if (d <= 0 || a == 0) return res;
      x = d <<< 32;
      root = '0;
      for (int b = 95; b >= 0; b--) begin
         tryv = root | (192'd1 << b);
         if (tryv * tryv <= $unsigned(x)) root = tryv;
      end
      nh = -(h <<< 16);
      for (int k = 0; k < 2; k++) begin
         cand = (k == 0) ? nh - wide_t'(root) : nh + wide_t'(root);
         q = cand / a;
         if (cand % a != 0 && cand < 0) q = q - 1;
         if (q > wide_t'(longint'(FIX_MAX))) tt = longint'(FIX_MAX);
         else if (q < wide_t'(longint'(FIX_MIN))) tt = longint'(FIX_MIN);
         else tt = longint'(q);
         if (tt > longint'(r.t_low) && tt < longint'(r.t_high)) begin
            res.hit = 1'b1;
            res.t = fix_type'(tt);
            for (int i = 0; i < 3; i++) begin
               pp = longint'(r.origin[i]) + ((tt * longint'(r.dir[i])) >>> 16);
               res.point[i] = sat32(pp);
               pp = longint'(res.point[i]);
               if (sph_radius > 0)
                  res.normal[i] = sat32(floor_div((pp - longint'(sph_center[i])) * ONE,
                                                  sph_radius));
            end
            return res;
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      hit_word_t e;
      if (reset) begin
         accepted_q <= 1'b0;
         sph_center = '{CENTER_RESET, CENTER_RESET, CENTER_RESET};
         sph_radius = longint'(RADIUS_RESET);
         idle_cycles = 0;
      end else begin
         accepted_q <= start && !busy;
         idle_cycles++;
         if (start && !busy) begin
            hit_q.push_back(trace_sphere(drv_ray));
            idle_cycles = 0;
         end
         if (csr_we) begin
            idle_cycles = 0;
            case (csr_index_type'(csr_index))
               CSR_CENTER_X: sph_center[0] = fix_type'(csr_wdata);
               CSR_CENTER_Y: sph_center[1] = fix_type'(csr_wdata);
               CSR_CENTER_Z: sph_center[2] = fix_type'(csr_wdata);
               CSR_RADIUS:   sph_radius = longint'(csr_wdata[RADIUS_W-1:0]);
            endcase
         end
         if (rsp_strobe) begin
            idle_cycles = 0;
            if (hit_q.size() == 0) begin
               $error("result word with no expectation waiting");
               errors++;
            end else begin
               e = hit_q.pop_front();
               check_field("is_hit", 32'(e.hit), 32'(rsp_is_hit));
               check_field("hit_t", e.t, rsp_hit_t);
               check_field("point_x", e.point[0], rsp_point_x);
               check_field("point_y", e.point[1], rsp_point_y);
               check_field("point_z", e.point[2], rsp_point_z);
               check_field("normal_x", e.normal[0], rsp_normal_x);
               check_field("normal_y", e.normal[1], rsp_normal_y);
               check_field("normal_z", e.normal[2], rsp_normal_z);
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // driver
   always @(negedge clock) begin
      job_t j;
      logic nxt_start, nxt_we;
      if (!reset) begin
         nxt_start = 1'b0;
         nxt_we = 1'b0;
         if (start && !accepted_q) begin
            nxt_start = 1'b1;
         end else if (gap_cnt > 0) begin
            gap_cnt--;
         end else if (draining) begin
            drain_cnt = (hit_q.size() == 0) ? drain_cnt + 1 : 0;
            if (drain_cnt >= DRAIN_CYCLES) draining = 1'b0;
         end else if (pend_q.size() > 0) begin
            j = pend_q.pop_front();
            if (j.gap > 0) begin
               gap_cnt = j.gap - 1;
               j.gap = 0;
               pend_q.push_front(j);
            end else begin
               case (j.kind)
                  JOB_RAY: begin
                     nxt_start = 1'b1;
                     drv_ray <= j.ray;
                  end
                  JOB_CSR: begin
                     nxt_we = 1'b1;
                     csr_index <= j.idx;
                     csr_wdata <= j.wdata;
                  end
                  JOB_DRAIN: begin
                     draining = 1'b1;
                     drain_cnt = 0;
                  end
               endcase
            end
         end
         start <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // stimulus
   longint gen_c[3];
   longint gen_r;
   bit     burst;

   function automatic longint rand_around(longint span);
      return longint'($urandom) % (2 * span + 1) - span;
   endfunction

   function automatic fix_type rand_fix();
      case ($urandom_range(0, 5))
         0: return FIX_MAX;
         1: return FIX_MIN;
         2: return sat32(rand_around(4 * ONE));
         default: return fix_type'($urandom);
      endcase
   endfunction

   task automatic add_ray(ray_type r);
      job_t j;
      j.kind = JOB_RAY;
      j.idx = CSR_CENTER_X;
      j.wdata = '0;
      j.ray = r;
      j.gap = burst ? 0 : $urandom_range(0, 16);
      pend_q.push_back(j);
   endtask

   task automatic add_ray6(longint ox, longint oy, longint oz, longint dx, longint dy,
                           longint dz, longint tl, longint th);
      ray_type r;
      r.origin = {sat32(oz), sat32(oy), sat32(ox)};
      r.dir = {sat32(dz), sat32(dy), sat32(dx)};
      r.t_low = sat32(tl);
      r.t_high = sat32(th);
      add_ray(r);
   endtask

   task automatic add_phase(longint cx, longint cy, longint cz, logic [31:0] rad_word);
      job_t j;
      j.kind = JOB_DRAIN;
      j.ray = '0;
      j.gap = 0;
      j.wdata = '0;
      j.idx = CSR_CENTER_X;
      pend_q.push_back(j);
      j.kind = JOB_CSR;
      j.wdata = 32'(cx);
      pend_q.push_back(j);
      j.idx = CSR_CENTER_Y;
      j.wdata = 32'(cy);
      pend_q.push_back(j);
      j.idx = CSR_CENTER_Z;
      j.wdata = 32'(cz);
      pend_q.push_back(j);
      j.idx = CSR_RADIUS;
      j.wdata = rad_word;
      pend_q.push_back(j);
      gen_c = '{longint'(fix_type'(cx)), longint'(fix_type'(cy)), longint'(fix_type'(cz))};
      gen_r = longint'(rad_word[RADIUS_W-1:0]);
   endtask

   // ray aimed near the sphere, random content
   task automatic add_aimed();
      longint o[3], d[3], span, sh;
      longint tl, th;
      span = (gen_r * 4 + ONE > 64'h3fff_ffff) ? 64'h3fff_ffff : gen_r * 4 + ONE;
      sh = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'(sat32(gen_c[i] + rand_around(span)));
         d[i] = (longint'(sat32(gen_c[i] + rand_around(gen_r > 0 ? gen_r : 1))) - o[i]);
         d[i] = ($urandom_range(0, 1)) ? (d[i] >>> sh) : d[i] * (sh + 1);
      end
      case ($urandom_range(0, 3))
         0: tl = 0;
         1: tl = -ONE;
         default: tl = rand_around(ONE);
      endcase
      case ($urandom_range(0, 3))
         0: th = longint'(FIX_MAX);
         1: th = 2 * ONE;
         default: th = rand_around(8 * ONE);
      endcase
      add_ray6(o[0], o[1], o[2], d[0], d[1], d[2], tl, th);
   endtask

   initial begin
      ray_type r;
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      drv_ray = '0;
      errors = 0;
      gap_cnt = 0;
      drain_cnt = 0;
      draining = 1'b0;
      burst = 1'b0;
      gen_c = '{0, 0, 0};
      gen_r = ONE;

      // directed, reset sphere: unit radius at the origin
      add_ray6(0, 0, -3 * ONE, 0, 0, ONE, 0, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, ONE, 2 * ONE, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, ONE, 0, 2 * ONE);
      add_ray6(0, 0, -3 * ONE, 0, 0, ONE, 2 * ONE, 4 * ONE);
      add_ray6(0, 0, 0, ONE, 0, 0, 0, FIX_MAX);
      add_ray6(0, 0, 0, 0, -ONE, 0, -4 * ONE, FIX_MAX);
      add_ray6(ONE, 0, -3 * ONE, 0, 0, ONE, 0, FIX_MAX);
      add_ray6(0, 0, 0, 0, 0, 0, FIX_MIN, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, -ONE, 0, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, 1, FIX_MIN, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, FIX_MAX, FIX_MIN, FIX_MAX);
      add_ray6(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX);
      add_ray6(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MAX);
      add_ray6(FIX_MIN, 0, 0, FIX_MAX, 0, 0, FIX_MIN, FIX_MAX);
      add_ray6(0, 0, -3 * ONE, 0, 0, ONE, FIX_MAX, FIX_MIN);
      add_ray6(ONE / 2, ONE / 2, -2 * ONE, 0, 0, 3 * ONE, FIX_MIN, FIX_MAX);
      add_ray6(-1, -1, -1, 1, 1, 1, FIX_MIN, FIX_MAX);
      add_ray6(0, 0, -1000 * ONE, 0, 0, ONE, 0, FIX_MAX);

      // register settings, extremes among them
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: add_phase(0, 0, 0, 32'(ONE));
            1: add_phase(FIX_MAX, FIX_MIN, FIX_MAX, 32'h7fff_ffff);
            2: add_phase(FIX_MIN, FIX_MAX, FIX_MIN, 32'd1);
            3: add_phase(ONE, -ONE, 0, 32'h8000_0000);
            4: add_phase(FIX_MIN, FIX_MIN, FIX_MIN, 32'hffff_ffff);
            5: add_phase($urandom, $urandom, $urandom, $urandom);
            default: add_phase(rand_around(64'h00ff_ffff), rand_around(64'h00ff_ffff),
                               rand_around(64'h00ff_ffff),
                               32'($urandom_range(16, 64'h003f_ffff)));
         endcase
         for (int n = 0; n < 215; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) != 0) begin
               add_aimed();
            end else begin
               r.origin = {rand_fix(), rand_fix(), rand_fix()};
               r.dir = {rand_fix(), rand_fix(), rand_fix()};
               r.t_low = rand_fix();
               r.t_high = rand_fix();
               add_ray(r);
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pend_q.size() > 0 || start || hit_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
